FILE: design/mct_pkg.sv
// Shared types, constants and register layout for the 4x4 column transform.
package mct_pkg;

  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;

  localparam int NREGS    = 8;
  localparam int REG_W    = 64;
  localparam int ELEM_W   = 32;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int PSUM_W   = PROD_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ADDR_W   = 6;
  localparam int IDX_LSB  = 3;
  localparam int IDX_W    = 3;
  localparam int HALF     = (DIM + 1) / 2;

  typedef logic [NREGS-1:0][REG_W-1:0] reg_arr_t;
  typedef logic [DIM-1:0][ELEM_W-1:0] row_t;

  // identity matrix
  localparam reg_arr_t REG_RESET = '{
    7: 64'h0001_0000_0000_0000,
    5: 64'h0000_0000_0001_0000,
    2: 64'h0001_0000_0000_0000,
    0: 64'h0000_0000_0001_0000,
    default: 64'h0
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] vec_in3;
    logic signed [ELEM_W-1:0] vec_in2;
    logic signed [ELEM_W-1:0] vec_in1;
    logic signed [ELEM_W-1:0] vec_in0;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] vec_out3;
    logic signed [ELEM_W-1:0] vec_out2;
    logic signed [ELEM_W-1:0] vec_out1;
    logic signed [ELEM_W-1:0] vec_out0;
  } out_t;

  typedef struct packed {
    logic adv_mul;
    logic adv_add;
  } ctrl_t;

endpackage

FILE: design/matrix_column_transform_4x4_core.sv
// Top level: config registers, one lane per row, pipeline control and output merge.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_stall  | in_data  (vec_in0..vec_in3)
//  out     | output    | out_valid / out_stall| out_data (vec_out0..vec_out3)
//  cfg     | input     | APB psel/penable     | 64-bit register at 8*index
//
// One request per cycle sustained while out_stall is low; a request passes the multiply
// stage, the half-sum stage, then the output register fed by the final add and clamp.
// Each stage holds when the one after it is full and not moving, so out_stall
// backs up to in_stall within the same cycle.
// Reset clears the stage valid flags and loads the identity matrix.
module matrix_column_transform_4x4_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mct_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mct_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mct_pkg::ADDR_W-1:0] paddr,
  input  logic [mct_pkg::REG_W-1:0]  pwdata,
  output logic [mct_pkg::REG_W-1:0]  prdata,
  output logic                       pready
);
  import mct_pkg::*;

  reg_arr_t regs;
  row_t     vec;
  row_t     a_rows [DIM];
  logic signed [ELEM_W-1:0] lane_res [DIM];
  logic signed [ELEM_W-1:0] res_full [4];

  logic  v1, v2;
  logic  adv1, adv2, adv3;
  ctrl_t ctrl;

  mct_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  always_comb begin
    vec[0] = in_data.vec_in0;
    if (DIM > 1) vec[1 % DIM] = in_data.vec_in1;
    if (DIM > 2) vec[2 % DIM] = in_data.vec_in2;
    if (DIM > 3) vec[3 % DIM] = in_data.vec_in3;
  end

  assign adv3     = v2 && (!out_valid || !out_stall);
  assign adv2     = v1 && (!v2 || adv3);
  assign adv1     = in_valid && (!v1 || adv2);
  assign in_stall = v1 && !adv2;

  assign ctrl.adv_mul = adv1;
  assign ctrl.adv_add = adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= adv1 || (v1 && !adv2);
      v2        <= adv2 || (v2 && !adv3);
      out_valid <= adv3 || (out_valid && out_stall);
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    for (genvar c = 0; c < DIM; c++) begin : g_col
      assign a_rows[r][c] = regs[c * 2 + r / 2][(r % 2) * ELEM_W +: ELEM_W];
    end

    mct_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .a_row  (a_rows[r]),
      .vec    (vec),
      .result (lane_res[r])
    );
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      res_full[r] = '0;
    end
    for (int r = 0; r < DIM; r++) begin
      res_full[r] = lane_res[r];
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (adv3) begin
      out_data.vec_out0 <= res_full[0];
      out_data.vec_out1 <= res_full[1];
      out_data.vec_out2 <= res_full[2];
      out_data.vec_out3 <= res_full[3];
    end
  end

endmodule

FILE: design/mct_cfg.sv
// APB register file holding the matrix entries, column-major, two per register.
module mct_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mct_pkg::ADDR_W-1:0]     paddr,
  input  logic [mct_pkg::REG_W-1:0]      pwdata,
  output logic [mct_pkg::REG_W-1:0]      prdata,
  output logic                           pready,
  output mct_pkg::reg_arr_t              regs
);
  import mct_pkg::*;

  logic [IDX_W-1:0] idx;

  assign idx    = paddr[IDX_LSB +: IDX_W];
  assign pready = 1'b1;
  assign prdata = regs[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (psel && penable && pwrite) begin
      regs[idx] <= pwdata;
    end
  end

endmodule

FILE: design/mct_lane.sv
// One result row: products, half sums, final sum with shift and saturation.
module mct_lane (
  input  logic                              clk,
  input  mct_pkg::ctrl_t                    ctrl,
  input  mct_pkg::row_t                     a_row,
  input  mct_pkg::row_t                     vec,
  output logic signed [mct_pkg::ELEM_W-1:0] result
);
  import mct_pkg::*;

  logic signed [PROD_W-1:0] prod [DIM];
  logic signed [PSUM_W-1:0] psum [2];
  logic signed [PSUM_W-1:0] psum_next [2];
  logic signed [ACC_W-1:0]  total;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.adv_mul) begin
      for (int k = 0; k < DIM; k++) begin
        prod[k] <= PROD_W'($signed(a_row[k])) * PROD_W'($signed(vec[k]));
      end
    end
  end

  always_comb begin
    psum_next[0] = '0;
    psum_next[1] = '0;
    for (int k = 0; k < DIM; k++) begin
      psum_next[k / HALF] = psum_next[k / HALF] + PSUM_W'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv_add) begin
      psum <= psum_next;
    end
  end

  // floor shift, then clamp when the upper bits are not a pure sign extension
  always_comb begin
    total   = ACC_W'(psum[0]) + ACC_W'(psum[1]);
    shifted = total >>> FRAC_BITS;
    if (shifted[ACC_W-1:ELEM_W-1] == '0 || shifted[ACC_W-1:ELEM_W-1] == '1) begin
      result = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      result = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

endmodule

FILE: bench/matrix_column_transform_4x4_core_test.sv
// Self-checking bench for the 4x4 column transform: APB matrix loads, random stalls, Q16.16 checks.
module matrix_column_transform_4x4_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ZERO = 32'h0000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV = 32'h8000_0000;
  localparam logic [31:0] NEG1 = 32'hFFFF_FFFF;
  localparam logic [31:0] LSB1 = 32'h0000_0001;

  localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO = -66'sh0_8000_0000;

  localparam int RANDOM_PHASES = 6;
  localparam int COLS_PER_PHASE = 200;

  typedef enum logic [2:0] {
    MAT_IDENT,
    MAT_ONES,
    MAT_ALL_MAX,
    MAT_ALL_MIN,
    MAT_TINY
  } mat_kind_e;

  typedef struct packed {
    mat_kind_e     mset;
    mct_pkg::in_t  col;
    bit            golden;
    mct_pkg::out_t want;
  } dir_row_t;

  // columns are written {b3, b2, b1, b0}; results {r3, r2, r1, r0}
  localparam dir_row_t DIR_ROWS [20] = '{
    '{MAT_IDENT, {ZERO, ZERO, ZERO, ZERO}, 1'b1, {ZERO, ZERO, ZERO, ZERO}},
    '{MAT_IDENT, {MAXV, MINV, NEG1, ONE}, 1'b1, {MAXV, MINV, NEG1, ONE}},
    '{MAT_IDENT, {32'h0003_8000, 32'hFFFE_0000, 32'h1234_5678, 32'h8765_4321}, 1'b1,
                 {32'h0003_8000, 32'hFFFE_0000, 32'h1234_5678, 32'h8765_4321}},
    '{MAT_IDENT, {32'hDEAD_BEEF, 32'h0F0F_F0F0, 32'h5555_AAAA, 32'hCAFE_0001}, 1'b0, '0},
    // all-ones matrix: every row is the saturated sum of the column
    '{MAT_ONES, {ZERO, ZERO, ZERO, MAXV}, 1'b1, {MAXV, MAXV, MAXV, MAXV}},
    '{MAT_ONES, {ZERO, ZERO, ONE, MAXV}, 1'b1, {MAXV, MAXV, MAXV, MAXV}},
    '{MAT_ONES, {ZERO, ZERO, ZERO, MINV}, 1'b1, {MINV, MINV, MINV, MINV}},
    '{MAT_ONES, {ZERO, ZERO, NEG1, MINV}, 1'b1, {MINV, MINV, MINV, MINV}},
    '{MAT_ONES, {MAXV, MAXV, MAXV, MAXV}, 1'b1, {MAXV, MAXV, MAXV, MAXV}},
    '{MAT_ALL_MAX, {MAXV, MAXV, MAXV, MAXV}, 1'b1, {MAXV, MAXV, MAXV, MAXV}},
    '{MAT_ALL_MAX, {MINV, MINV, MINV, MINV}, 1'b1, {MINV, MINV, MINV, MINV}},
    '{MAT_ALL_MAX, {ZERO, ZERO, ZERO, ONE}, 1'b1, {MAXV, MAXV, MAXV, MAXV}},
    '{MAT_ALL_MIN, {MINV, MINV, MINV, MINV}, 1'b1, {MAXV, MAXV, MAXV, MAXV}},
    '{MAT_ALL_MIN, {MAXV, MAXV, MAXV, MAXV}, 1'b1, {MINV, MINV, MINV, MINV}},
    '{MAT_ALL_MIN, {ZERO, ZERO, ZERO, LSB1}, 1'b1,
                   {32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000}},
    '{MAT_ALL_MIN, {ZERO, ZERO, ZERO, ONE}, 1'b1, {MINV, MINV, MINV, MINV}},
    // tiny matrix: entries are one LSB, so results are small and the shift rounds toward minus infinity
    '{MAT_TINY, {ZERO, ZERO, ZERO, NEG1}, 1'b1, {NEG1, NEG1, NEG1, NEG1}},
    '{MAT_TINY, {ZERO, ZERO, ZERO, LSB1}, 1'b1, {ZERO, ZERO, ZERO, ZERO}},
    '{MAT_TINY, {ONE, ONE, ONE, ONE}, 1'b1, {32'h4, 32'h4, 32'h4, 32'h4}},
    '{MAT_TINY, {32'h8001_2345, 32'h7FFE_0000, 32'hFFFF_0001, 32'h0000_FFFF}, 1'b0, '0}
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  mct_pkg::in_t                       in_data = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  mct_pkg::out_t                      out_data;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [mct_pkg::ADDR_W-1:0]         paddr = '0;
  logic [mct_pkg::REG_W-1:0]          pwdata = '0;
  logic [mct_pkg::REG_W-1:0]          prdata;
  logic                               pready;

  mct_pkg::reg_arr_t coef;
  mct_pkg::out_t     pending_cols[$];
  int unsigned       mismatch_count = 0;
  bit                calm = 1'b0;

  matrix_column_transform_4x4_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("TB_ERROR");
    $finish;
  end

  // r = A * b, exact 66-bit row sums, arithmetic shift, clamp to 32 bits
  function automatic mct_pkg::out_t column_product(mct_pkg::reg_arr_t a, mct_pkg::in_t b);
    logic [3:0][31:0]       bw;
    logic [3:0][31:0]       rw;
    logic signed [31:0]     entry;
    logic signed [63:0]     prod;
    logic signed [65:0]     acc;
    logic signed [65:0]     shifted;
    bw = b;
    for (int row = 0; row < 4; row++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        entry = a[2 * k + row / 2][32 * (row % 2) +: 32];
        prod = entry * $signed(bw[k]);
        acc = acc + prod;
      end
      shifted = acc >>> mct_pkg::FRAC_BITS;
      if (shifted > SAT_HI) begin
        rw[row] = MAXV;
      end else if (shifted < SAT_LO) begin
        rw[row] = MINV;
      end else begin
        rw[row] = shifted[31:0];
      end
    end
    return mct_pkg::out_t'(rw);
  endfunction

  function automatic mct_pkg::reg_arr_t matrix_of(mat_kind_e kind);
    mct_pkg::reg_arr_t m;
    logic [31:0]       e;
    e = ZERO;
    case (kind)
      MAT_ONES:    e = ONE;
      MAT_ALL_MAX: e = MAXV;
      MAT_ALL_MIN: e = MINV;
      MAT_TINY:    e = LSB1;
      default:     e = ZERO;
    endcase
    for (int i = 0; i < mct_pkg::NREGS; i++) begin
      m[i] = {e, e};
    end
    if (kind == MAT_IDENT) begin
      m[0] = {ZERO, ONE};
      m[2] = {ONE, ZERO};
      m[5] = {ZERO, ONE};
      m[7] = {ONE, ZERO};
    end
    return m;
  endfunction

  // bias toward the corners of Q16.16, keep plenty of full-range words
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return MAXV;
      1:       return MINV;
      2:       return ZERO;
      3:       return ONE;
      4:       return NEG1;
      5, 6:    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %s: expected %h, got %h", what, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(0, 99) < 20);
  end

  always @(posedge clk) begin : check_results
    logic [3:0][31:0] want_w;
    logic [3:0][31:0] got_w;
    if (!rst && out_valid && !out_stall) begin
      got_w = out_data;
      if (pending_cols.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got_w[1:0]);
      end else begin
        want_w = pending_cols.pop_front();
        for (int f = 0; f < 4; f++) begin
          if (got_w[f] !== want_w[f]) begin
            report_mismatch($sformatf("vec_out%0d", f), 64'(want_w[f]), 64'(got_w[f]));
          end
        end
      end
    end
  end

  task automatic push_column(mct_pkg::in_t col, mct_pkg::out_t want);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      in_data <= {$urandom(), $urandom(), $urandom(), $urandom()};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_cols.push_back(want);
  endtask

  // hold off new requests until the pipeline is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_cols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(int unsigned idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= mct_pkg::ADDR_W'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(int unsigned idx, output logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= mct_pkg::ADDR_W'(idx * 8);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_matrix();
    logic [63:0] rd;
    for (int i = 0; i < mct_pkg::NREGS; i++) begin
      apb_read(i, rd);
      if (rd !== coef[i]) begin
        report_mismatch($sformatf("readback of register %0d", i), coef[i], rd);
      end
    end
  endtask

  task automatic load_matrix(mct_pkg::reg_arr_t m);
    for (int i = 0; i < mct_pkg::NREGS; i++) begin
      apb_write(i, m[i]);
    end
    coef = m;
    verify_matrix();
  endtask

  initial begin : stimulus
    mct_pkg::reg_arr_t m;
    mct_pkg::in_t      col;
    mat_kind_e         cur;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset leaves the identity in place
    coef = matrix_of(MAT_IDENT);
    verify_matrix();
    cur = MAT_IDENT;

    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].mset != cur) begin
        wait_drained();
        cur = DIR_ROWS[r].mset;
        load_matrix(matrix_of(cur));
      end
      col = DIR_ROWS[r].col;
      push_column(col, DIR_ROWS[r].golden ? DIR_ROWS[r].want : column_product(coef, col));
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      for (int i = 0; i < mct_pkg::NREGS; i++) begin
        case (phase % 3)
          0:       m[i] = {$urandom(), $urandom()};
          1:       m[i] = {rand_word(), rand_word()};
          default: m[i] = {$urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                           $urandom_range(0, 32'h0004_0000) - 32'h0002_0000};
        endcase
      end
      load_matrix(m);
      calm = (phase == 3);
      for (int n = 0; n < COLS_PER_PHASE; n++) begin
        col = {rand_word(), rand_word(), rand_word(), rand_word()};
        push_column(col, column_product(coef, col));
      end
      calm = 1'b0;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
